// ===== hw/rtl/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants of the streaming inversion counter
// Item and result structs, the per-level token of the cell chain, memory
// request bundle, controller states and tree geometry helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sic_pkg;

  // Tree geometry
  localparam int MAX_RANKS = 1024;
  localparam int RANK_W    = 11;
  localparam int NODE_W    = 16;
  localparam int ITEMS_W   = 17;
  localparam int TOTAL_W   = 32;

  // One cell per Fenwick level: level k holds the nodes whose lowest set bit is 2^k
  localparam int LEVELS = $clog2(MAX_RANKS + 1);
  localparam int DEPTH0 = (MAX_RANKS + 1) >> 1;
  localparam int ADDR_W = (DEPTH0 > 1) ? $clog2(DEPTH0) : 1;
  localparam int ACC_W  = NODE_W + $clog2(LEVELS);

  localparam logic [RANK_W-1:0] RANK_LIMIT       = RANK_W'(MAX_RANKS);
  localparam logic [RANK_W-1:0] RESET_RANK_COUNT = RANK_W'(MAX_RANKS);
  localparam logic [NODE_W-1:0] NODE_MAX         = '1;
  localparam logic [ITEMS_W-1:0] ITEMS_MAX       = '1;
  localparam logic [ADDR_W-1:0] SWEEP_LAST       = ADDR_W'(DEPTH0 - 1);

  typedef struct packed {
    logic [RANK_W-1:0] rank_value;
    logic              end_of_run;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] inversion_total;
    logic               run_done;
  } out_item_t;

  // Token handed from cell to cell; rank and size arrive shifted by the level
  typedef struct packed {
    logic              started;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] size;
    logic [ACC_W-1:0]  acc;
  } token_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } clear_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BUSY,
    ST_FIN
  } state_e;

  // Number of tree nodes up to MAX_RANKS whose lowest set bit is 2^level
  function automatic int level_depth(input int level);
    return ((MAX_RANKS >> level) + 1) >> 1;
  endfunction

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== hw/rtl/sic_ram.sv =====
// ----------------------------------------------------------------------------
// sic_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sic_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sic_cell.sv =====
// ----------------------------------------------------------------------------
// sic_cell: one level of the Fenwick tree
// Looks up the level's node for the passing token, adds it to the prefix
// sum where the query path crosses this level, bumps it where the update
// path does, then hands the token on with rank and size shifted by one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sic_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tok_valid_i,
  input  sic_pkg::token_t           tok_i,
  input  sic_pkg::clear_t           clr_i,
  input  logic [sic_pkg::NODE_W-1:0] rdata_i,
  output logic                      tok_valid_o,
  output sic_pkg::token_t           tok_o,
  output sic_pkg::ram_req_t         ram_o
);

  import sic_pkg::*;

  logic              valid_q;
  token_t            tok_q;
  logic              bit_here;
  logic              upd_path;
  logic              upd_fit;
  logic              upd_en;
  logic [NODE_W-1:0] node_inc;

  // Register the incoming token alongside the node read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_i;
  end

  // Query hits nodes where the rank bit is set; update starts at the lowest
  // set bit and then hits each level whose rank bit is clear
  always_comb begin
    bit_here = tok_q.rank[0];
    upd_path = tok_q.started ^ bit_here;
    upd_fit  = ((tok_q.rank | RANK_W'(1)) <= tok_q.size);
    upd_en   = valid_q && upd_path && upd_fit;
    node_inc = (rdata_i == NODE_MAX) ? rdata_i : rdata_i + NODE_W'(1);
  end

  // Read at the token's node, write back the bump or the sweep's zero
  always_comb begin
    ram_o.raddr = ADDR_W'(tok_i.rank >> 1);
    ram_o.we    = clr_i.en || upd_en;
    ram_o.waddr = clr_i.en ? clr_i.addr : ADDR_W'(tok_q.rank >> 1);
    ram_o.wdata = clr_i.en ? '0 : node_inc;
  end

  // Advance the token to the next level
  always_comb begin
    tok_valid_o   = valid_q;
    tok_o.started = tok_q.started | bit_here;
    tok_o.rank    = tok_q.rank >> 1;
    tok_o.size    = tok_q.size >> 1;
    tok_o.acc     = tok_q.acc + (bit_here ? ACC_W'(rdata_i) : '0);
  end

endmodule

// ===== hw/rtl/streaming_inversion_counter.sv =====
// ----------------------------------------------------------------------------
// streaming_inversion_counter: running inversion count over a rank stream
// Only one transaction is taken at a time: no new one is accepted until the
// result of the last has been registered. The token walks one cell per cycle
// through the 11 tree levels and the total then takes two steps.
// After reset, and after every transaction flagged end_of_run, the tree is
// swept to zero, during which no transaction is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module streaming_inversion_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sic_pkg::RANK_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sic_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sic_pkg::out_item_t          out_item_o
);

  import sic_pkg::*;

  state_e             state_q, state_d;
  logic [RANK_W-1:0]  rank_count_q;
  logic [RANK_W-1:0]  size_w;
  logic [RANK_W-1:0]  rank_w;
  logic               in_accept;
  logic               head_valid_q;
  token_t             head_q;
  logic               last_q;
  logic [ADDR_W-1:0]  sweep_q;
  clear_t             clr;
  logic               out_free;
  logic               fin_fire;
  logic [ITEMS_W-1:0] items_q;
  logic [TOTAL_W-1:0] total_q;
  logic [ITEMS_W-1:0] greater_q;
  logic [ITEMS_W-1:0] greater_d;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat;
  logic [ITEMS_W-1:0] items_inc;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic [LEVELS:0]    tok_valid;
  token_t             tok     [LEVELS+1];
  ram_req_t           ram_req [LEVELS];
  logic [NODE_W-1:0]  rdata   [LEVELS];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= RESET_RANK_COUNT;
    end else if (cfg_we_i) begin
      rank_count_q <= cfg_data_i;
    end
  end

  // Clamp the tree size and the incoming rank
  always_comb begin
    if (rank_count_q == '0) begin
      size_w = RANK_W'(1);
    end else if (rank_count_q > RANK_LIMIT) begin
      size_w = RANK_LIMIT;
    end else begin
      size_w = rank_count_q;
    end
    if (in_item_i.rank_value == '0) begin
      rank_w = RANK_W'(1);
    end else if (in_item_i.rank_value > size_w) begin
      rank_w = size_w;
    end else begin
      rank_w = in_item_i.rank_value;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: if (sweep_q == SWEEP_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_BUSY;
      ST_BUSY:  if (tok_valid[LEVELS]) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = last_q ? ST_SWEEP : ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    clr.en     = (state_q == ST_SWEEP);
    clr.addr   = sweep_q;
    out_free   = !out_valid_q || !out_stall_i;
    fin_fire   = (state_q == ST_FIN) && out_free;
  end

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // Sweep address, wraps back to zero at the end of each pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (clr.en) begin
      sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + ADDR_W'(1);
    end
  end

  // Launch a token into the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else begin
      head_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      head_q.started <= 1'b0;
      head_q.rank    <= rank_w;
      head_q.size    <= size_w;
      head_q.acc     <= '0;
      last_q         <= in_item_i.end_of_run;
    end
  end

  assign tok_valid[0] = head_valid_q;
  assign tok[0]       = head_q;

  // Chain of tree levels, each with its own node memory
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam int DEPTH = level_depth(k);
    localparam int AW    = addr_width(DEPTH);

    sic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tok_valid[k]),
      .tok_i       (tok[k]),
      .clr_i       (clr),
      .rdata_i     (rdata[k]),
      .tok_valid_o (tok_valid[k+1]),
      .tok_o       (tok[k+1]),
      .ram_o       (ram_req[k])
    );

    sic_ram #(
      .DEPTH (DEPTH),
      .WIDTH (NODE_W),
      .AW    (AW)
    ) u_ram (
      .clk_i   (clk_i),
      .raddr_i (ram_req[k].raddr[AW-1:0]),
      .we_i    (ram_req[k].we),
      .waddr_i (ram_req[k].waddr[AW-1:0]),
      .wdata_i (ram_req[k].wdata),
      .rdata_o (rdata[k])
    );
  end

  // Earlier items of the run with a greater rank; zero if the sum overshoots
  always_comb begin
    if (ACC_W'(items_q) > tok[LEVELS].acc) begin
      greater_d = ITEMS_W'(ACC_W'(items_q) - tok[LEVELS].acc);
    end else begin
      greater_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid[LEVELS]) begin
      greater_q <= greater_d;
    end
  end

  // Saturating total and item count
  always_comb begin
    total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(greater_q);
    total_sat = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    items_inc = (items_q == ITEMS_MAX) ? items_q : items_q + ITEMS_W'(1);
  end

  // Update run state; drop it after an end-of-run transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      items_q <= '0;
    end else if (fin_fire) begin
      if (last_q) begin
        total_q <= '0;
        items_q <= '0;
      end else begin
        total_q <= total_sat;
        items_q <= items_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_item_q.inversion_total <= total_sat;
      out_item_q.run_done        <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Only one transaction travels the chain at a time
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one token in the cell chain");

  // A token leaves the chain only while the controller waits for it
  a_exit_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid[LEVELS] |-> (state_q == ST_BUSY))
    else $error("token left the chain outside the busy state");

  // The sweep walks every address without a break
  a_sweep_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && (sweep_q != SWEEP_LAST) |=>
      (state_q == ST_SWEEP) && (sweep_q == $past(sweep_q) + ADDR_W'(1)))
    else $error("tree sweep interrupted");

  // The item count only grows within a run
  a_items_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SWEEP) |=> (items_q >= $past(items_q)) || (state_q == ST_SWEEP))
    else $error("item count fell within a run");

endmodule
